/* sv/wbxml_token_scanner_defines.svh */
// Assertion macros for the WBXML token scanner.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef WBXML_TOKEN_SCANNER_DEFINES_SVH
`define WBXML_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/wts_pkg.sv */
// Shared types and constants for the WBXML token scanner.
// No dependencies; imported by wbxml_token_scanner.
`timescale 1ns / 1ps

package wts_pkg;

  localparam int unsigned LENGTH_WIDTH_DEF = 32;
  localparam logic [15:0] DEFAULT_CHARSET_RST = 16'd106;

  // register indexes on the config port
  localparam logic REG_DEFAULT_CHARSET = 1'b0;

  // global body tokens
  localparam logic [7:0] TOK_SWITCH_PAGE = 8'h00;
  localparam logic [7:0] TOK_END         = 8'h01;
  localparam logic [7:0] TOK_ENTITY      = 8'h02;
  localparam logic [7:0] TOK_STR_I       = 8'h03;
  localparam logic [7:0] TOK_LITERAL     = 8'h04;
  localparam logic [7:0] TOK_EXT_I_0     = 8'h40;
  localparam logic [7:0] TOK_EXT_I_1     = 8'h41;
  localparam logic [7:0] TOK_EXT_I_2     = 8'h42;
  localparam logic [7:0] TOK_PI          = 8'h43;
  localparam logic [7:0] TOK_EXT_T_0     = 8'h80;
  localparam logic [7:0] TOK_EXT_T_1     = 8'h81;
  localparam logic [7:0] TOK_EXT_T_2     = 8'h82;
  localparam logic [7:0] TOK_STR_T       = 8'h83;
  localparam logic [7:0] TOK_EXT_0       = 8'hC0;
  localparam logic [7:0] TOK_EXT_1       = 8'hC1;
  localparam logic [7:0] TOK_EXT_2       = 8'hC2;
  localparam logic [7:0] TOK_OPAQUE      = 8'hC3;

  typedef enum logic [16:0] {
    PH_VERSION = 17'h00001,
    PH_PUBID   = 17'h00002,
    PH_PUBIDX  = 17'h00004,
    PH_CHARSET = 17'h00008,
    PH_TLEN    = 17'h00010,
    PH_TABLE   = 17'h00020,
    PH_TOKEN   = 17'h00040,
    PH_SWITCH  = 17'h00080,
    PH_ENTITY  = 17'h00100,
    PH_INLINE  = 17'h00200,
    PH_EXTSTR  = 17'h00400,
    PH_STRT    = 17'h00800,
    PH_EXTINT  = 17'h01000,
    PH_OPQLEN  = 17'h02000,
    PH_OPQDATA = 17'h04000,
    PH_LITTAG  = 17'h08000,
    PH_LITATTR = 17'h10000
  } phase_e;

  typedef enum logic [4:0] {
    K_PUBID       = 5'd0,
    K_PUBID_IDX   = 5'd1,
    K_CHARSET     = 5'd2,
    K_TABLE_BYTE  = 5'd3,
    K_TAG         = 5'd4,
    K_LIT_TAG     = 5'd5,
    K_END_TAG     = 5'd6,
    K_END_ATTRS   = 5'd7,
    K_PI          = 5'd8,
    K_INLINE_BYTE = 5'd9,
    K_INLINE_END  = 5'd10,
    K_ENTITY      = 5'd11,
    K_TABLE_REF   = 5'd12,
    K_ATTR_START  = 5'd13,
    K_ATTR_LIT    = 5'd14,
    K_ATTR_VALUE  = 5'd15,
    K_OPQ_BYTE    = 5'd16,
    K_OPQ_EMPTY   = 5'd17,
    K_TABLE_ERR   = 5'd18
  } kind_e;

endpackage

/* sv/wbxml_token_scanner.sv */
// WBXML token scanner top level: header parse, body tokenizer, APB config register.
// Depends on wts_pkg and wbxml_token_scanner_defines.svh.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata = data_byte, tuser = doc_start
//  m_axis    out  tvalid/tready             tdata = value/flags, tuser = kind, tlast
//  apb       in   psel/penable/pwrite/rdy   one register: default_charset at 0x0
//
// One byte per cycle while s_axis_tready is high: each accepted byte updates the parse
// state and, when it produces an event, loads the result register in the same edge.
// s_axis_tready is high whenever the result register is empty or being drained.
// Reset puts the parser at the version byte and default_charset at 106.
// A byte with tuser set restarts the parse (the register keeps its value).
`timescale 1ns / 1ps

`include "wbxml_token_scanner_defines.svh"

module wbxml_token_scanner
  import wts_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] doc_start
  // event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [32] has_attrs, [33] has_content
  output logic [4:0]  m_axis_tuser,   // [4:0] kind
  output logic        m_axis_tlast,   // is_last
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- config register ----------------
  logic [15:0] charset_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEFAULT_CHARSET) ? {16'b0, charset_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_q <= DEFAULT_CHARSET_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_DEFAULT_CHARSET)) begin
      charset_q <= pwdata[15:0];
    end
  end

  // ---------------- parse state ----------------
  localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

  phase_e                  phase_q, phase_d, phase_e_v;
  logic [31:0]             acc_q, acc_d, acc_e, acc_shift;
  logic                    tag_mode_q, tag_mode_d, tag_mode_e;
  logic                    content_q, content_d, content_e;
  logic [7:0]              tpage_q, tpage_d, tpage_e;
  logic [7:0]              apage_q, apage_d, apage_e;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d, rem_e, len_v;
  logic                    stop_q, stop_d, stop_e;

  logic        in_fire, out_ready;
  logic        ev_valid;
  kind_e       ev_kind;
  logic [31:0] ev_value;
  logic        ev_attrs, ev_content, ev_last;
  logic [7:0]  b;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = out_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  // state as seen by this byte: a document start restarts the parse first
  always_comb begin
    if (s_axis_tuser) begin
      phase_e_v  = PH_VERSION;
      acc_e      = 32'b0;
      tag_mode_e = 1'b1;
      content_e  = 1'b0;
      tpage_e    = 8'b0;
      apage_e    = 8'b0;
      rem_e      = '0;
      stop_e     = 1'b0;
    end else begin
      phase_e_v  = phase_q;
      acc_e      = acc_q;
      tag_mode_e = tag_mode_q;
      content_e  = content_q;
      tpage_e    = tpage_q;
      apage_e    = apage_q;
      rem_e      = rem_q;
      stop_e     = stop_q;
    end
  end

  assign acc_shift = {acc_e[24:0], b[6:0]};
  assign len_v     = acc_shift[LENGTH_WIDTH-1:0];

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    tag_mode_d = tag_mode_q;
    content_d  = content_q;
    tpage_d    = tpage_q;
    apage_d    = apage_q;
    rem_d      = rem_q;
    stop_d     = stop_q;
    ev_valid   = 1'b0;
    ev_kind    = K_TAG;
    ev_value   = 32'b0;
    ev_attrs   = 1'b0;
    ev_content = 1'b0;
    ev_last    = 1'b0;

    if (in_fire) begin
      phase_d    = phase_e_v;
      acc_d      = acc_e;
      tag_mode_d = tag_mode_e;
      content_d  = content_e;
      tpage_d    = tpage_e;
      apage_d    = apage_e;
      rem_d      = rem_e;
      stop_d     = stop_e;

      if (!stop_e) begin
        case (phase_e_v)
          PH_VERSION: begin
            phase_d = PH_PUBID;
          end
          PH_TABLE: begin
            rem_d    = rem_e - LEN_ONE;
            ev_valid = 1'b1;
            ev_kind  = K_TABLE_BYTE;
            ev_value = {24'b0, b};
            if (rem_e == LEN_ONE) begin
              phase_d = PH_TOKEN;
              if (b != 8'b0) begin
                // unterminated string table: report and go quiet
                stop_d  = 1'b1;
                ev_kind = K_TABLE_ERR;
              end else begin
                ev_last = 1'b1;
              end
            end
          end
          PH_TOKEN: begin
            case (b)
              TOK_SWITCH_PAGE: phase_d = PH_SWITCH;
              TOK_END: begin
                ev_valid   = 1'b1;
                ev_kind    = K_END_TAG;
                tag_mode_d = 1'b1;
                if (!tag_mode_e && content_e) ev_kind = K_END_ATTRS;
              end
              TOK_ENTITY: phase_d = PH_ENTITY;
              TOK_STR_I:  phase_d = PH_INLINE;
              TOK_EXT_I_0, TOK_EXT_I_1, TOK_EXT_I_2: phase_d = PH_EXTSTR;
              TOK_PI: begin
                tag_mode_d = 1'b0;
                content_d  = 1'b0;
                ev_valid   = 1'b1;
                ev_kind    = K_PI;
              end
              TOK_EXT_T_0, TOK_EXT_T_1, TOK_EXT_T_2: phase_d = PH_EXTINT;
              TOK_STR_T:  phase_d = PH_STRT;
              TOK_EXT_0, TOK_EXT_1, TOK_EXT_2: begin
              end
              TOK_OPAQUE: phase_d = PH_OPQLEN;
              default: begin
                if (tag_mode_e) begin
                  if (b[7]) tag_mode_d = 1'b0;
                  content_d = b[6];
                  if (b[5:0] == TOK_LITERAL[5:0]) begin
                    phase_d = PH_LITTAG;
                  end else begin
                    ev_valid   = 1'b1;
                    ev_kind    = K_TAG;
                    ev_value   = {18'b0, tpage_e, b[5:0]};
                    ev_attrs   = b[7];
                    ev_content = b[6];
                  end
                end else if (b == TOK_LITERAL) begin
                  phase_d = PH_LITATTR;
                end else begin
                  ev_valid = 1'b1;
                  ev_kind  = b[7] ? K_ATTR_VALUE : K_ATTR_START;
                  ev_value = {16'b0, apage_e, b};
                end
              end
            endcase
          end
          PH_SWITCH: begin
            if (tag_mode_e) tpage_d = b;
            else            apage_d = b;
            phase_d = PH_TOKEN;
          end
          PH_INLINE: begin
            ev_valid = 1'b1;
            if (b == 8'b0) begin
              phase_d = PH_TOKEN;
              ev_kind = K_INLINE_END;
            end else begin
              ev_kind  = K_INLINE_BYTE;
              ev_value = {24'b0, b};
            end
          end
          PH_EXTSTR: begin
            if (b == 8'b0) phase_d = PH_TOKEN;
          end
          PH_OPQDATA: begin
            rem_d    = rem_e - LEN_ONE;
            ev_valid = 1'b1;
            ev_kind  = K_OPQ_BYTE;
            ev_value = {24'b0, b};
            if (rem_e == LEN_ONE) begin
              phase_d = PH_TOKEN;
              ev_last = 1'b1;
            end
          end
          PH_PUBID, PH_PUBIDX, PH_CHARSET, PH_TLEN, PH_ENTITY, PH_STRT,
          PH_EXTINT, PH_OPQLEN, PH_LITTAG, PH_LITATTR: begin
            // multibyte integer, seven bits per byte, last byte has bit 7 clear
            acc_d = acc_shift;
            if (!b[7]) begin
              acc_d    = 32'b0;
              phase_d  = PH_TOKEN;
              ev_value = acc_shift;
              case (phase_e_v)
                PH_PUBID: begin
                  ev_valid = 1'b1;
                  ev_kind  = K_PUBID;
                  phase_d  = (acc_shift == 32'b0) ? PH_PUBIDX : PH_CHARSET;
                end
                PH_PUBIDX: begin
                  ev_valid = 1'b1;
                  ev_kind  = K_PUBID_IDX;
                  phase_d  = PH_CHARSET;
                end
                PH_CHARSET: begin
                  ev_valid = 1'b1;
                  ev_kind  = K_CHARSET;
                  phase_d  = PH_TLEN;
                  if (acc_shift == 32'b0) ev_value = {16'b0, charset_q};
                end
                PH_TLEN: begin
                  rem_d = len_v;
                  if (len_v != '0) phase_d = PH_TABLE;
                end
                PH_ENTITY: begin
                  ev_valid = 1'b1;
                  ev_kind  = K_ENTITY;
                end
                PH_STRT: begin
                  ev_valid = 1'b1;
                  ev_kind  = K_TABLE_REF;
                end
                PH_EXTINT: begin
                end
                PH_OPQLEN: begin
                  rem_d = len_v;
                  if (len_v != '0) begin
                    phase_d = PH_OPQDATA;
                  end else begin
                    ev_valid = 1'b1;
                    ev_kind  = K_OPQ_EMPTY;
                    ev_value = 32'b0;
                  end
                end
                PH_LITTAG: begin
                  ev_valid   = 1'b1;
                  ev_kind    = K_LIT_TAG;
                  ev_attrs   = !tag_mode_e;
                  ev_content = content_e;
                end
                default: begin
                  ev_valid = 1'b1;
                  ev_kind  = K_ATTR_LIT;
                end
              endcase
            end
          end
          default: begin
            phase_d = PH_TOKEN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_VERSION;
      acc_q      <= 32'b0;
      tag_mode_q <= 1'b1;
      content_q  <= 1'b0;
      tpage_q    <= 8'b0;
      apage_q    <= 8'b0;
      rem_q      <= '0;
      stop_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      tag_mode_q <= tag_mode_d;
      content_q  <= content_d;
      tpage_q    <= tpage_d;
      apage_q    <= apage_d;
      rem_q      <= rem_d;
      stop_q     <= stop_d;
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [31:0] out_value_q;
  logic        out_attrs_q, out_content_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_fire && ev_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_kind_q    <= ev_kind;
      out_value_q   <= ev_value;
      out_attrs_q   <= ev_attrs;
      out_content_q <= ev_content;
      out_last_q    <= ev_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_content_q, out_attrs_q, out_value_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------- checks ----------------
  `WTS_ASSERT_NEXT(a_stopped_silent,
    in_fire && stop_q && !s_axis_tuser, !out_valid_q,
    "scanner produced an item while stopped")

  `WTS_ASSERT_NOW(a_err_sets_stop,
    out_valid_q && (out_kind_q == K_TABLE_ERR), stop_q,
    "table error reported without entering the stopped state")

  `WTS_ASSERT_NOW(a_last_kinds,
    out_valid_q && out_last_q,
    (out_kind_q == K_TABLE_BYTE) || (out_kind_q == K_OPQ_BYTE),
    "last flag on an item that is not a table or opaque byte")

  `WTS_ASSERT_NOW(a_flags_tags_only,
    out_valid_q && (out_attrs_q || out_content_q),
    (out_kind_q == K_TAG) || (out_kind_q == K_LIT_TAG),
    "tag flags set on a non-tag item")

endmodule
